// ===== hdl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, command codes and ring arithmetic for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

    // buffer geometry follows the 8-bit head index of the result item
    localparam int IDX_W = 8;
    localparam int CNT_W = IDX_W + 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int CMD_W = 3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_REPLACE = 3'd2,
        CMD_SKIP    = 3'd3,
        CMD_FLUSH   = 3'd4
    } cmd_e;

    // advance an index by n (n <= size) around a ring of the given size
    function automatic idx_t ring_add(idx_t idx, cnt_t n, cnt_t size);
        cnt_t sum;
        sum = {1'b0, idx} + n;
        if (sum >= size)
        begin
            sum = sum - size;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/brf_if.sv =====
// ----------------------------------------------------------------------------
// brf_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface brf_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [brf_pkg::CMD_W-1:0]   command;
    logic [7:0]                  data_byte;
    logic [7:0]                  offset;
    logic [brf_pkg::CNT_W-1:0]   skip_count;

    modport source (output valid, command, data_byte, offset, skip_count, input ready);
    modport sink   (input valid, command, data_byte, offset, skip_count, output ready);
endinterface

interface brf_res_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [7:0]                  read_byte;
    logic [brf_pkg::CNT_W-1:0]   fill_count;
    logic [brf_pkg::CNT_W-1:0]   free_space;
    logic [brf_pkg::IDX_W-1:0]   head_index;
    logic [brf_pkg::CNT_W-1:0]   contiguous_len;

    modport source (output valid, ok, read_byte, fill_count, free_space, head_index,
                    contiguous_len, input ready);
    modport sink   (input valid, ok, read_byte, fill_count, free_space, head_index,
                    contiguous_len, output ready);
endinterface

// ===== hdl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hdl/byte_ring_fifo_with_patch_and_skip_top.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_patch_and_skip_top
// Byte ring FIFO with push, pop, replace at offset, skip and flush commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command item per handshake (push, pop, replace, skip,
//   flush); res_ch returns exactly one result item per command, in order.
//   cfg_we/cfg_data set the ring length (0 acts as 1, above 256 acts as 256)
//   and empty the ring; write it only while no command is in flight.
//   Path: a command passes through the read stage (registered read of the
//   byte store) and then the output register before its result is valid.
//   Throughput: one command per cycle while res_ch takes results. Ring
//   pointers and fill count sit in registers, so each command updates them
//   in its accept cycle, and the single store port serves any access it needs.
//   A pop reads the store the cycle the command is accepted; a later write
//   to the same cell lands on a later edge, so no forwarding is needed.
//   Reset: ring empty, length 256; store contents stay undefined.
//   Stall: a result waiting on res_ch holds, one more command may sit in the
//   read stage, and cmd_ch drops ready until the result is taken.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_patch_and_skip_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [brf_pkg::CNT_W-1:0] cfg_data,
    brf_cmd_if.sink                   cmd_ch,
    brf_res_if.source                 res_ch
);

    // result fields that do not depend on the store read
    typedef struct packed {
        logic                      ok;
        logic                      take_byte;
        logic [brf_pkg::CNT_W-1:0] fill_count;
        logic [brf_pkg::CNT_W-1:0] free_space;
        logic [brf_pkg::IDX_W-1:0] head_index;
        logic [brf_pkg::CNT_W-1:0] contiguous_len;
    } stage_t;

    localparam brf_pkg::cnt_t FULL_SIZE = brf_pkg::cnt_t'(brf_pkg::DEPTH);

    brf_pkg::cnt_t size_reg, size_next;
    brf_pkg::idx_t wr_reg, wr_next;
    brf_pkg::idx_t rd_reg, rd_next;
    brf_pkg::cnt_t held_reg, held_next;

    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;
    logic   out_valid_reg;
    stage_t out_reg;
    logic [7:0] out_byte_reg;

    logic          accept;
    logic          s1_move;
    logic          ram_we;
    logic          ram_re;
    brf_pkg::idx_t ram_addr;
    logic [7:0]    ram_rdata;

    // handshake
    assign s1_move      = !out_valid_reg || res_ch.ready;
    assign cmd_ch.ready = !s1_valid_reg || s1_move;
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    // clamp the ring length written through the config port
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            size_next = brf_pkg::cnt_t'(1);
        end
        else if (cfg_data > FULL_SIZE)
        begin
            size_next = FULL_SIZE;
        end
        else
        begin
            size_next = cfg_data;
        end
    end

    // command decode and pointer update
    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        held_next = held_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = rd_reg;
        s1_next   = '0;

        unique case (cmd_ch.command)
            brf_pkg::CMD_PUSH:
            begin
                if (held_reg < size_reg)
                begin
                    s1_next.ok = 1'b1;
                    ram_we     = accept;
                    ram_addr   = wr_reg;
                    wr_next    = brf_pkg::ring_add(wr_reg, brf_pkg::cnt_t'(1), size_reg);
                    held_next  = held_reg + brf_pkg::cnt_t'(1);
                end
            end
            brf_pkg::CMD_POP:
            begin
                if (held_reg != '0)
                begin
                    s1_next.ok        = 1'b1;
                    s1_next.take_byte = 1'b1;
                    ram_re            = accept;
                    rd_next   = brf_pkg::ring_add(rd_reg, brf_pkg::cnt_t'(1), size_reg);
                    held_next = held_reg - brf_pkg::cnt_t'(1);
                end
            end
            brf_pkg::CMD_REPLACE:
            begin
                if ({1'b0, cmd_ch.offset} < held_reg)
                begin
                    s1_next.ok = 1'b1;
                    ram_we     = accept;
                    ram_addr   = brf_pkg::ring_add(rd_reg, {1'b0, cmd_ch.offset}, size_reg);
                end
            end
            brf_pkg::CMD_SKIP:
            begin
                if (cmd_ch.skip_count != '0 && cmd_ch.skip_count <= held_reg)
                begin
                    s1_next.ok = 1'b1;
                    rd_next    = brf_pkg::ring_add(rd_reg, cmd_ch.skip_count, size_reg);
                    held_next  = held_reg - cmd_ch.skip_count;
                end
            end
            brf_pkg::CMD_FLUSH:
            begin
                s1_next.ok = 1'b1;
                wr_next    = '0;
                rd_next    = '0;
                held_next  = '0;
            end
            default:
            begin
                s1_next.ok = 1'b0;
            end
        endcase

        // ring status after the command
        s1_next.fill_count = held_next;
        s1_next.free_space = size_reg - held_next;
        s1_next.head_index = rd_next;
        if (held_next == '0)
        begin
            s1_next.contiguous_len = '0;
        end
        else if (rd_next >= wr_next)
        begin
            s1_next.contiguous_len = size_reg - {1'b0, rd_next};
        end
        else
        begin
            s1_next.contiguous_len = held_next;
        end
    end

    // byte store
    brf_ram #(
        .WIDTH (8),
        .DEPTH (brf_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (cmd_ch.data_byte),
        .rdata (ram_rdata)
    );

    // ring control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= FULL_SIZE;
            wr_reg   <= '0;
            rd_reg   <= '0;
            held_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= size_next;
            wr_reg   <= '0;
            rd_reg   <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            held_reg <= held_next;
        end
    end

    // read stage and output register valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && s1_move)
        begin
            out_reg      <= s1_reg;
            out_byte_reg <= s1_reg.take_byte ? ram_rdata : 8'd0;
        end
    end

    assign res_ch.valid          = out_valid_reg;
    assign res_ch.ok             = out_reg.ok;
    assign res_ch.read_byte      = out_byte_reg;
    assign res_ch.fill_count     = out_reg.fill_count;
    assign res_ch.free_space     = out_reg.free_space;
    assign res_ch.head_index     = out_reg.head_index;
    assign res_ch.contiguous_len = out_reg.contiguous_len;

    // checks
    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= size_reg && size_reg != '0 && size_reg <= FULL_SIZE)
        else $error("fill count exceeds ring length");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wr_reg} < size_reg && {1'b0, rd_reg} < size_reg)
        else $error("ring pointer beyond ring length");

    // the read data only matters while a pop sits in the read stage
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_reg) &&
                                     (!s1_reg.take_byte || $stable(ram_rdata)))
        else $error("read stage lost its item during a stall");

    a_byte_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.take_byte |-> out_byte_reg == 8'd0)
        else $error("nonzero byte on a result that is not a pop");

endmodule

// ===== tb/brf_checker.sv =====
// ----------------------------------------------------------------------------
// brf_checker
// Watches the command and result channels of the byte ring FIFO. Keeps its
// own copy of the ring (cells, head/tail pointers, fill level, ring length),
// works out the status of every accepted command item and compares each
// accepted result item field by field against the oldest pending status.
// ----------------------------------------------------------------------------
module brf_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [brf_pkg::CNT_W-1:0] cfg_data,
    brf_cmd_if                        cmd_mon,
    brf_res_if                        res_mon,
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic          ok;
        logic [7:0]    rbyte;
        brf_pkg::cnt_t fill;
        brf_pkg::cnt_t free;
        brf_pkg::idx_t head;
        brf_pkg::cnt_t contig;
    } ring_status_t;

    // shadow ring
    brf_pkg::cnt_t ring_len = brf_pkg::cnt_t'(brf_pkg::DEPTH);
    brf_pkg::idx_t head_ptr = '0;
    brf_pkg::idx_t tail_ptr = '0;
    brf_pkg::cnt_t held     = '0;
    logic [7:0]    cells [brf_pkg::DEPTH];

    ring_status_t status_q [$];
    ring_status_t want;
    int           fail_total = 0;
    int           seen_total = 0;

    assign mismatches   = fail_total;
    assign results_seen = seen_total;
    assign outstanding  = status_q.size();

    // move a pointer n cells forward around the current ring length
    function automatic brf_pkg::idx_t step_ptr(brf_pkg::idx_t p, int n);
        int s;
        s = int'(p) + n;
        if (s >= int'(ring_len))
        begin
            s = s - int'(ring_len);
        end
        return brf_pkg::idx_t'(s);
    endfunction

    // apply one command to the shadow ring, return the status after it
    function automatic ring_status_t apply_command(logic [brf_pkg::CMD_W-1:0] c,
                                                   logic [7:0] d, logic [7:0] o,
                                                   brf_pkg::cnt_t k);
        ring_status_t st;
        st = '0;
        case (c)
            brf_pkg::CMD_PUSH:
            begin
                if (held < ring_len)
                begin
                    cells[tail_ptr] = d;
                    tail_ptr = step_ptr(tail_ptr, 1);
                    held = held + 1'b1;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::CMD_POP:
            begin
                if (held != 0)
                begin
                    st.rbyte = cells[head_ptr];
                    head_ptr = step_ptr(head_ptr, 1);
                    held = held - 1'b1;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::CMD_REPLACE:
            begin
                if (brf_pkg::cnt_t'(o) < held)
                begin
                    cells[step_ptr(head_ptr, int'(o))] = d;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::CMD_SKIP:
            begin
                if (k != 0 && k <= held)
                begin
                    head_ptr = step_ptr(head_ptr, int'(k));
                    held = held - k;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::CMD_FLUSH:
            begin
                head_ptr = '0;
                tail_ptr = '0;
                held = '0;
                st.ok = 1'b1;
            end
            default:
            begin
                // spare codes: rejected, ring untouched
            end
        endcase
        st.fill = held;
        st.free = ring_len - held;
        st.head = head_ptr;
        if (held != 0)
        begin
            st.contig = (head_ptr >= tail_ptr) ? ring_len - brf_pkg::cnt_t'(head_ptr) : held;
        end
        return st;
    endfunction

    function automatic void check_field(string name, logic [8:0] exp_v, logic [8:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            fail_total++;
        end
    endfunction

    // predict on command accept, compare on result accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len = brf_pkg::cnt_t'(brf_pkg::DEPTH);
            head_ptr = '0;
            tail_ptr = '0;
            held     = '0;
            status_q.delete();
        end
        else
        begin
            // length write also empties the ring; 0 acts as 1, overlarge as DEPTH
            if (cfg_we)
            begin
                if (cfg_data == 0)
                    ring_len = brf_pkg::cnt_t'(1);
                else if (cfg_data > brf_pkg::cnt_t'(brf_pkg::DEPTH))
                    ring_len = brf_pkg::cnt_t'(brf_pkg::DEPTH);
                else
                    ring_len = cfg_data;
                head_ptr = '0;
                tail_ptr = '0;
                held     = '0;
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                status_q.push_back(apply_command(cmd_mon.command, cmd_mon.data_byte,
                                                 cmd_mon.offset, cmd_mon.skip_count));
            end
            if (res_mon.valid && res_mon.ready)
            begin
                seen_total++;
                if (status_q.size() == 0)
                begin
                    $error("result item with no command item waiting");
                    fail_total++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("ok", 9'(want.ok), 9'(res_mon.ok));
                    check_field("read_byte", 9'(want.rbyte), 9'(res_mon.read_byte));
                    check_field("fill_count", want.fill, res_mon.fill_count);
                    check_field("free_space", want.free, res_mon.free_space);
                    check_field("head_index", 9'(want.head), 9'(res_mon.head_index));
                    check_field("contiguous_len", want.contig, res_mon.contiguous_len);
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression for the byte ring FIFO. Drives directed corner commands, then
// fill bursts and random command mixes over a range of ring lengths, with
// random gaps on both channels and one long result-side stall. Checking is
// done by brf_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the block does not implement
    localparam logic [brf_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [brf_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [brf_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int MIX_ITEMS   = 140;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    brf_pkg::cnt_t cfg_data = '0;

    brf_cmd_if cmd_ch ();
    brf_res_if res_ch ();

    int  fails;
    int  pending;
    int  checked;
    int  sent = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    brf_pkg::cnt_t ring_settings [10] = '{9'd1, 9'd2, 9'd0, 9'd511, 9'd3,
                                          9'd257, 9'd17, 9'd100, 9'd255, 9'd256};

    byte_ring_fifo_with_patch_and_skip_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_ch   (cmd_ch),
        .res_ch   (res_ch)
    );

    brf_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd_mon      (cmd_ch),
        .res_mon      (res_ch),
        .mismatches   (fails),
        .outstanding  (pending),
        .results_seen (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("byte_ring_fifo_with_patch_and_skip_top regression: fail");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    // offer one command item and wait for it to be taken
    task automatic send_item(logic [brf_pkg::CMD_W-1:0] c, logic [7:0] d, logic [7:0] o,
                             brf_pkg::cnt_t k);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.command    = c;
        cmd_ch.data_byte  = d;
        cmd_ch.offset     = o;
        cmd_ch.skip_count = k;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // drop valid and let every pending result drain
    task automatic wait_idle();
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_ring_len(brf_pkg::cnt_t v);
        wait_idle();
        cfg_data = v;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
        @(negedge clk);
    endtask

    task automatic fill_ring(int n);
        repeat (n) send_item(brf_pkg::CMD_PUSH, 8'($urandom()), 8'($urandom()),
                             9'($urandom()));
    endtask

    // random command mix, push share given in percent
    task automatic random_mix(int n, int push_pct);
        int            r;
        int            sub;
        logic [7:0]    o;
        brf_pkg::cnt_t k;
        repeat (n)
        begin
            r   = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            o   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
            r   = (r < push_pct) ? -1 : r;
            if (sub < 70)
                k = 9'($urandom_range(1, 4));
            else if (sub < 80)
                k = '0;
            else
                k = 9'($urandom_range(0, 511));
            sub = $urandom_range(0, 99);
            if (r < 0)
                send_item(brf_pkg::CMD_PUSH, 8'($urandom()), o, k);
            else if (sub < 45)
                send_item(brf_pkg::CMD_POP, 8'($urandom()), o, k);
            else if (sub < 70)
                send_item(brf_pkg::CMD_REPLACE, 8'($urandom()), o, k);
            else if (sub < 92)
                send_item(brf_pkg::CMD_SKIP, 8'($urandom()), o, k);
            else if (sub < 96)
                send_item(brf_pkg::CMD_FLUSH, 8'($urandom()), o, k);
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_item(CMD_SPARE_5, 8'($urandom()), o, k);
                    1: send_item(CMD_SPARE_6, 8'($urandom()), o, k);
                    default: send_item(CMD_SPARE_7, 8'($urandom()), o, k);
                endcase
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int eff;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = brf_pkg::CMD_PUSH;
        cmd_ch.data_byte  = '0;
        cmd_ch.offset     = '0;
        cmd_ch.skip_count = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corners at the reset length of 256
        send_item(brf_pkg::CMD_POP, 8'h00, 8'h00, 9'd0);         // pop on empty
        send_item(brf_pkg::CMD_SKIP, 8'h00, 8'h00, 9'd0);        // zero skip
        send_item(brf_pkg::CMD_SKIP, 8'h00, 8'h00, 9'd1);        // skip on empty
        send_item(brf_pkg::CMD_REPLACE, 8'h11, 8'h00, 9'd0);     // replace on empty
        send_item(CMD_SPARE_5, 8'hFF, 8'hFF, 9'd511);
        send_item(CMD_SPARE_6, 8'h00, 8'h00, 9'd0);
        send_item(CMD_SPARE_7, 8'hFF, 8'hFF, 9'd256);
        send_item(brf_pkg::CMD_PUSH, 8'h00, 8'h00, 9'd0);
        send_item(brf_pkg::CMD_PUSH, 8'hFF, 8'hFF, 9'd511);
        send_item(brf_pkg::CMD_PUSH, 8'hA5, 8'h00, 9'd0);
        send_item(brf_pkg::CMD_REPLACE, 8'h5A, 8'h01, 9'd0);
        send_item(brf_pkg::CMD_REPLACE, 8'h77, 8'h03, 9'd0);     // offset equal to fill
        send_item(brf_pkg::CMD_REPLACE, 8'h77, 8'hFF, 9'd0);
        send_item(brf_pkg::CMD_POP, 8'h00, 8'h00, 9'd0);
        send_item(brf_pkg::CMD_SKIP, 8'h00, 8'h00, 9'd3);        // more than held
        send_item(brf_pkg::CMD_SKIP, 8'h00, 8'h00, 9'd2);
        send_item(brf_pkg::CMD_PUSH, 8'h3C, 8'h00, 9'd0);
        send_item(brf_pkg::CMD_FLUSH, 8'h00, 8'h00, 9'd0);
        send_item(brf_pkg::CMD_POP, 8'h00, 8'h00, 9'd0);

        // fill the full ring, then push on full, patch the tail, skip everything
        fill_ring(257);
        send_item(brf_pkg::CMD_REPLACE, 8'hC3, 8'hFF, 9'd0);
        send_item(brf_pkg::CMD_SKIP, 8'h00, 8'h00, 9'd511);
        send_item(brf_pkg::CMD_SKIP, 8'h00, 8'h00, 9'd256);
        send_item(brf_pkg::CMD_POP, 8'h00, 8'h00, 9'd0);

        // random mixes over several ring lengths
        foreach (ring_settings[p])
        begin
            write_ring_len(ring_settings[p]);
            no_idle = (p % 4 == 3);
            eff = (ring_settings[p] == 0) ? 1 :
                  (ring_settings[p] > brf_pkg::DEPTH) ? brf_pkg::DEPTH :
                  int'(ring_settings[p]);
            fill_ring((eff <= 64) ? eff + 1 : 24);
            if (p == 7)
                hold_req = 1'b1;
            random_mix(MIX_ITEMS, (p % 2 == 1) ? 65 : 40);
        end
        no_idle = 1'b0;
        wait_idle();
        repeat (5) @(negedge clk);

        $display("covered %0d command items, %0d result items checked, %0d ring length writes",
                 sent, checked, $size(ring_settings));
        $display("including full and empty rings, spare codes and one long result stall");
        if (fails == 0)
            $display("byte_ring_fifo_with_patch_and_skip_top regression: pass");
        else
            $display("byte_ring_fifo_with_patch_and_skip_top regression: fail");
        $finish;
    end

endmodule
